>>> hw/rtl/bll_pkg.sv
// Shared types, command and status codes and default sizes for the
// bounded linked list engine. No dependencies; the interfaces, the engine and the testbench use it.
package bll_pkg;

	localparam int DEPTH_DEFAULT     = 32;
	localparam int KEY_WIDTH_DEFAULT = 32;

	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int ITEM_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int WIDE_W   = 64;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_OUT  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLY,
		ST_INSERT,
		ST_WALK
	} state_t;

endpackage

>>> hw/rtl/bll_if.sv
// Valid/ready channel interfaces for the command and response sides of the
// bounded linked list engine. Depends on bll_pkg for the field widths.
interface bll_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [bll_pkg::CMD_W-1:0]            cmd;
	logic signed [bll_pkg::ITEM_W-1:0]    key_value;

	modport source(output valid, cmd, key_value, input ready);
	modport sink(input valid, cmd, key_value, output ready);
endinterface

interface bll_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [bll_pkg::STATUS_W-1:0]         status;
	logic signed [bll_pkg::ITEM_W-1:0]    item_value;
	logic [bll_pkg::COUNT_W-1:0]          entry_count;
	logic                                 last_result;

	modport source(output valid, status, item_value, entry_count, last_result, input ready);
	modport sink(input valid, status, item_value, entry_count, last_result, output ready);
endinterface

>>> hw/rtl/bll_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/bounded_linked_list_engine_unit.sv
// Top level of the bounded linked list engine: sequencer, list registers and
// output register. Depends on bll_pkg, bll_if (channels) and bll_ram.
//
// The request channel carries one command per beat: insert at front, insert
// at end, search, delete or read out. The response channel returns one beat
// per result; last_result marks the final beat of a command. Inserts, searches
// and deletes give one beat, a read out gives one beat per list entry, or one on an empty list.
// Keys live in a key RAM and a link RAM read at one shared address; free slots
// sit on a stack in a third RAM. Commands are handled one at a time, and the
// request side is ready only while the sequencer is idle.
// After a command is accepted, an insert or an immediate reply loads the output
// register from the INSERT or REPLY state. Search and delete walk one entry per
// cycle through the link RAM read port and load it at the match or the last entry.
// A read out loads one result per cycle while the receiver keeps up. The request
// side reopens in the cycle after the final load.
// A result waits in the output register while the receiver stalls; a read out
// then pauses its walk, other commands hold their final step until the beat
// goes out. Reset empties the list at once: the free stack needs no clearing
// pass because slots that were never handed out are numbered by a low-water
// mark. Key and link RAM contents are not cleared.
module bounded_linked_list_engine_unit #(
	parameter int DEPTH     = bll_pkg::DEPTH_DEFAULT,
	parameter int KEY_WIDTH = bll_pkg::KEY_WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	bll_cmd_if.sink          request,
	bll_rsp_if.source        response
);

	localparam int SW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int COUNT_W  = bll_pkg::COUNT_W;
	localparam int ITEM_W   = bll_pkg::ITEM_W;
	localparam int WIDE_W   = bll_pkg::WIDE_W;
	localparam int STATUS_W = bll_pkg::STATUS_W;
	localparam int CMD_W    = bll_pkg::CMD_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	bll_pkg::state_t state_q, state_d;

	// List bookkeeping.
	logic [SW-1:0] head_q, tail_q;
	logic [CW-1:0] len_q, free_top_q, low_q;

	// Command context.
	logic [CMD_W-1:0]    cmd_q;
	logic [ITEM_W-1:0]   req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [STATUS_W-1:0] status_q;
	logic [SW-1:0]       cur_q, prev_q;
	logic [CW-1:0]       idx_q;

	// Output register.
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [ITEM_W-1:0]    out_item_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_last_q;

	// Memory ports.
	logic [KEY_WIDTH-1:0] key_rd;
	logic [SW-1:0]        link_rd, free_rd;
	logic [SW-1:0]        list_raddr;
	logic                 key_we, link_we, free_we;
	logic [SW-1:0]        link_waddr, link_wdata;

	// Sequencer strobes and result fields.
	logic                 accept, advance, do_insert, do_delete, load;
	logic [STATUS_W-1:0]  status_d, ld_status;
	logic [ITEM_W-1:0]    ld_item;
	logic [COUNT_W-1:0]   ld_count;
	logic                 ld_last;

	logic                 can_load, last_idx, match, front;
	logic [CW-1:0]        pop_idx, fresh_slot;
	logic [SW-1:0]        slot;
	logic [WIDE_W-1:0]    key_in_wide, key_out_wide;
	logic [KEY_WIDTH-1:0] key_in;
	logic [ITEM_W-1:0]    key_out;

	assign key_in_wide  = WIDE_W'(request.key_value);
	assign key_in       = key_in_wide[KEY_WIDTH-1:0];
	assign key_out_wide = WIDE_W'(signed'(key_rd));
	assign key_out      = key_out_wide[ITEM_W-1:0];

	assign can_load = !out_valid_q || response.ready;
	assign last_idx = (idx_q + CW'(1)) == len_q;
	assign match    = key_rd == key_q;
	assign front    = cmd_q == bll_pkg::CMD_INS_FRONT;

	// Stack entries below the low-water mark were never written; their slot numbers
	// are worked out here instead, counting up from slot 0 at the top.
	assign pop_idx    = free_top_q - CW'(1);
	assign fresh_slot = DEPTH_C - CW'(1) - pop_idx;
	assign slot       = (pop_idx >= low_q) ? free_rd : fresh_slot[SW-1:0];

	always_comb begin
		state_d    = state_q;
		request.ready = 1'b0;
		accept     = 1'b0;
		advance    = 1'b0;
		do_insert  = 1'b0;
		do_delete  = 1'b0;
		load       = 1'b0;
		status_d   = bll_pkg::STATUS_NOT_FOUND;
		ld_status  = status_q;
		ld_item    = req_q;
		ld_count   = COUNT_W'(len_q);
		ld_last    = 1'b1;
		list_raddr = cur_q;

		case (state_q)
			bll_pkg::ST_IDLE: begin
				request.ready = 1'b1;
				list_raddr    = head_q;
				if (request.valid) begin
					accept = 1'b1;
					case (request.cmd)
						bll_pkg::CMD_INS_FRONT, bll_pkg::CMD_INS_END: begin
							if (len_q >= DEPTH_C || free_top_q == '0) begin
								status_d = bll_pkg::STATUS_FULL;
								state_d  = bll_pkg::ST_REPLY;
							end else begin
								state_d = bll_pkg::ST_INSERT;
							end
						end
						bll_pkg::CMD_SEARCH: begin
							status_d = bll_pkg::STATUS_NOT_FOUND;
							state_d  = (len_q == '0) ? bll_pkg::ST_REPLY : bll_pkg::ST_WALK;
						end
						bll_pkg::CMD_DELETE, bll_pkg::CMD_READ_OUT: begin
							status_d = bll_pkg::STATUS_EMPTY;
							state_d  = (len_q == '0) ? bll_pkg::ST_REPLY : bll_pkg::ST_WALK;
						end
						default: begin
							state_d = bll_pkg::ST_IDLE;
						end
					endcase
				end
			end
			bll_pkg::ST_REPLY: begin
				if (can_load) begin
					load    = 1'b1;
					ld_item = (cmd_q == bll_pkg::CMD_READ_OUT) ? '0 : req_q;
					state_d = bll_pkg::ST_IDLE;
				end
			end
			bll_pkg::ST_INSERT: begin
				if (can_load) begin
					do_insert = 1'b1;
					load      = 1'b1;
					ld_status = bll_pkg::STATUS_INSERTED;
					ld_count  = COUNT_W'(len_q + CW'(1));
					state_d   = bll_pkg::ST_IDLE;
				end
			end
			bll_pkg::ST_WALK: begin
				// The RAMs hold the entry at cur_q; advancing issues the read
				// of its successor, stalling re-reads the same entry.
				if (cmd_q == bll_pkg::CMD_READ_OUT) begin
					if (can_load) begin
						load      = 1'b1;
						ld_status = bll_pkg::STATUS_FOUND;
						ld_item   = key_out;
						ld_last   = last_idx;
						if (last_idx) begin
							state_d = bll_pkg::ST_IDLE;
						end else begin
							advance = 1'b1;
						end
					end
				end else if (match || last_idx) begin
					if (can_load) begin
						load = 1'b1;
						if (!match) begin
							ld_status = bll_pkg::STATUS_NOT_FOUND;
						end else if (cmd_q == bll_pkg::CMD_DELETE) begin
							do_delete = 1'b1;
							ld_status = bll_pkg::STATUS_DELETED;
							ld_count  = COUNT_W'(len_q - CW'(1));
						end else begin
							ld_status = bll_pkg::STATUS_FOUND;
						end
						state_d = bll_pkg::ST_IDLE;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance) begin
					list_raddr = link_rd;
				end
			end
			default: begin
				state_d = bll_pkg::ST_IDLE;
			end
		endcase
	end

	// Write ports: an insert stores the key and, unless the list was empty, one link;
	// a delete splices out one link unless it removes the head, and pushes the freed slot.
	always_comb begin
		key_we     = do_insert;
		link_we    = 1'b0;
		link_waddr = prev_q;
		link_wdata = link_rd;
		free_we    = do_delete;
		if (do_insert) begin
			link_we    = len_q != '0;
			link_waddr = front ? slot : tail_q;
			link_wdata = front ? head_q : slot;
		end else if (do_delete) begin
			link_we = idx_q != '0;
		end
	end

	bll_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot),
		.wdata (key_q),
		.raddr (list_raddr),
		.rdata (key_rd)
	);

	bll_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (list_raddr),
		.rdata (link_rd)
	);

	bll_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_top_q[SW-1:0]),
		.wdata (cur_q),
		.raddr (pop_idx[SW-1:0]),
		.rdata (free_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			len_q       <= '0;
			free_top_q  <= DEPTH_C;
			low_q       <= DEPTH_C;
			out_valid_q <= 1'b0;
		end else begin
			if (do_insert) begin
				free_top_q <= pop_idx;
				len_q      <= len_q + CW'(1);
				if (pop_idx < low_q) begin
					low_q <= pop_idx;
				end
				if (len_q == '0) begin
					head_q <= slot;
					tail_q <= slot;
				end else if (front) begin
					head_q <= slot;
				end else begin
					tail_q <= slot;
				end
			end else if (do_delete) begin
				free_top_q <= free_top_q + CW'(1);
				len_q      <= len_q - CW'(1);
				if (idx_q == '0) begin
					head_q <= link_rd;
				end
				if (last_idx) begin
					tail_q <= prev_q;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= request.cmd;
			req_q    <= request.key_value;
			key_q    <= key_in;
			status_q <= status_d;
			cur_q    <= head_q;
			prev_q   <= head_q;
			idx_q    <= '0;
		end else if (advance) begin
			prev_q <= cur_q;
			cur_q  <= link_rd;
			idx_q  <= idx_q + CW'(1);
		end
		if (load) begin
			out_status_q <= ld_status;
			out_item_q   <= ld_item;
			out_count_q  <= ld_count;
			out_last_q   <= ld_last;
		end
	end

	assign response.valid       = out_valid_q;
	assign response.status      = out_status_q;
	assign response.item_value  = out_item_q;
	assign response.entry_count = out_count_q;
	assign response.last_result = out_last_q;

endmodule

>>> dv/bounded_linked_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_linked_list_engine_unit: directed and random
// command streams; a scoreboard mirrors the key list. Uses bll_pkg, bll_if and the engine.
module bounded_linked_list_engine_unit_tb;

	localparam int LIST_DEPTH    = bll_pkg::DEPTH_DEFAULT;
	localparam int KEY_W         = bll_pkg::KEY_WIDTH_DEFAULT;
	localparam int TOTAL_ITEMS   = 110;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = LIST_DEPTH + 8;

	typedef struct {
		logic [bll_pkg::STATUS_W-1:0]      status;
		logic signed [bll_pkg::ITEM_W-1:0] item_value;
		logic [bll_pkg::COUNT_W-1:0]       entry_count;
		logic                              last_result;
	} rsp_beat_t;

	class key_list_scoreboard #(int DEPTH = 32, int KW = 32);
		logic [KW-1:0] list_keys[$];
		rsp_beat_t     expected_beats[$];
		int            errors = 0;

		function logic [KW-1:0] to_key(logic signed [bll_pkg::ITEM_W-1:0] v);
			logic signed [63:0] wide;
			wide = v;
			return wide[KW-1:0];
		endfunction

		function logic signed [bll_pkg::ITEM_W-1:0] to_item(logic [KW-1:0] k);
			logic signed [63:0] wide;
			wide = $signed(k);
			return wide[bll_pkg::ITEM_W-1:0];
		endfunction

		function void add_beat(logic [bll_pkg::STATUS_W-1:0] status,
				logic signed [bll_pkg::ITEM_W-1:0] item, logic last);
			rsp_beat_t b;
			b.status      = status;
			b.item_value  = item;
			b.entry_count = bll_pkg::COUNT_W'(list_keys.size());
			b.last_result = last;
			expected_beats.push_back(b);
		endfunction

		// Works out the beats that one accepted command causes and updates the list.
		function void note_command(logic [bll_pkg::CMD_W-1:0] cmd,
				logic signed [bll_pkg::ITEM_W-1:0] req);
			logic [KW-1:0] key;
			int hit;
			int i;
			key = to_key(req);
			hit = -1;
			for (i = 0; i < list_keys.size(); i++) begin
				if (hit < 0 && list_keys[i] == key)
					hit = i;
			end
			case (cmd)
				bll_pkg::CMD_INS_FRONT, bll_pkg::CMD_INS_END: begin
					if (list_keys.size() >= DEPTH) begin
						add_beat(bll_pkg::STATUS_FULL, req, 1'b1);
					end else begin
						if (cmd == bll_pkg::CMD_INS_FRONT)
							list_keys.push_front(key);
						else
							list_keys.push_back(key);
						add_beat(bll_pkg::STATUS_INSERTED, req, 1'b1);
					end
				end
				bll_pkg::CMD_SEARCH: begin
					add_beat((hit >= 0) ? bll_pkg::STATUS_FOUND : bll_pkg::STATUS_NOT_FOUND,
						req, 1'b1);
				end
				bll_pkg::CMD_DELETE: begin
					if (list_keys.size() == 0) begin
						add_beat(bll_pkg::STATUS_EMPTY, req, 1'b1);
					end else if (hit < 0) begin
						add_beat(bll_pkg::STATUS_NOT_FOUND, req, 1'b1);
					end else begin
						list_keys.delete(hit);
						add_beat(bll_pkg::STATUS_DELETED, req, 1'b1);
					end
				end
				bll_pkg::CMD_READ_OUT: begin
					if (list_keys.size() == 0) begin
						add_beat(bll_pkg::STATUS_EMPTY, '0, 1'b1);
					end else begin
						for (i = 0; i < list_keys.size(); i++)
							add_beat(bll_pkg::STATUS_FOUND, to_item(list_keys[i]),
								i == list_keys.size() - 1);
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("tb: mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_beat(rsp_beat_t got);
			rsp_beat_t exp;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("response beat with none expected, status %0d item %0h",
					got.status, got.item_value));
			end else begin
				exp = expected_beats.pop_front();
				if (got.status !== exp.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						got.status, exp.status));
				if (got.item_value !== exp.item_value)
					report_mismatch($sformatf("item_value got %0h expected %0h",
						got.item_value, exp.item_value));
				if (got.entry_count !== exp.entry_count)
					report_mismatch($sformatf("entry_count got %0d expected %0d",
						got.entry_count, exp.entry_count));
				if (got.last_result !== exp.last_result)
					report_mismatch($sformatf("last_result got %0d expected %0d",
						got.last_result, exp.last_result));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	bll_cmd_if request_ch();
	bll_rsp_if response_ch();

	bounded_linked_list_engine_unit #(
		.DEPTH     (LIST_DEPTH),
		.KEY_WIDTH (KEY_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch)
	);

	key_list_scoreboard #(LIST_DEPTH, KEY_W) sb;

	int sender_idle_pct;
	int stall_pct;
	int known_items;
	int quiet_cycles;
	logic signed [bll_pkg::ITEM_W-1:0] key_pool[8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		response_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			response_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : rsp_monitor
		rsp_beat_t got;
		if (arst_n && response_ch.valid && response_ch.ready) begin
			got.status      = response_ch.status;
			got.item_value  = response_ch.item_value;
			got.entry_count = response_ch.entry_count;
			got.last_result = response_ch.last_result;
			sb.check_beat(got);
		end
	end

	// Any beat on either side counts as progress.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((request_ch.valid && request_ch.ready) ||
				(response_ch.valid && response_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin sender_idle_pct = 0;  stall_pct = 0;  end
			1: begin sender_idle_pct = 80; stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  stall_pct = 80; end
			default: begin sender_idle_pct = 20; stall_pct = 20; end
		endcase
	endtask

	// Presents one command and returns at the edge that accepts it. The beat is
	// noted here so that the list mirror is current when the next one is chosen.
	task automatic send_command(logic [bll_pkg::CMD_W-1:0] cmd,
			logic signed [bll_pkg::ITEM_W-1:0] key);
		while ($urandom_range(99) < sender_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid     <= 1'b1;
		request_ch.cmd       <= cmd;
		request_ch.key_value <= key;
		do @(posedge clk); while (!request_ch.ready);
		sb.note_command(cmd, key);
		if (cmd <= bll_pkg::CMD_READ_OUT)
			known_items++;
	endtask

	task automatic wait_drained();
		request_ch.valid <= 1'b0;
		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		// Ignored commands give no beat, so allow the engine time to settle.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [bll_pkg::ITEM_W-1:0] pick_key();
		if ($urandom_range(9) < 6)
			return key_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic logic [bll_pkg::CMD_W-1:0] pick_insert();
		return $urandom_range(1) ? bll_pkg::CMD_INS_END : bll_pkg::CMD_INS_FRONT;
	endfunction

	function automatic logic [bll_pkg::CMD_W-1:0] pick_unknown();
		return bll_pkg::CMD_W'($urandom_range(7, bll_pkg::CMD_READ_OUT + 1));
	endfunction

	task automatic fill_burst();
		while (sb.list_keys.size() < LIST_DEPTH) begin
			if ($urandom_range(19) == 0)
				send_command(pick_unknown(), $urandom);
			send_command(pick_insert(), pick_key());
		end
		// Two more inserts land on a full list.
		send_command(pick_insert(), pick_key());
		send_command(pick_insert(), $urandom);
		send_command(bll_pkg::CMD_READ_OUT, $urandom);
		send_command(bll_pkg::CMD_SEARCH, pick_key());
	endtask

	task automatic mixed_burst();
		int n;
		int sel;
		for (n = 0; n < 15; n++) begin
			sel = $urandom_range(19);
			if (sel < 7)
				send_command(pick_insert(), pick_key());
			else if (sel < 11)
				send_command(bll_pkg::CMD_SEARCH, pick_key());
			else if (sel < 16)
				send_command(bll_pkg::CMD_DELETE, pick_key());
			else if (sel < 19)
				send_command(bll_pkg::CMD_READ_OUT, $urandom);
			else
				send_command(pick_unknown(), $urandom);
		end
	endtask

	task automatic drain_burst();
		logic [KEY_W-1:0] remaining[$];
		int idx;
		remaining = sb.list_keys;
		while (remaining.size() != 0) begin
			idx = $urandom_range(remaining.size() - 1);
			send_command(bll_pkg::CMD_DELETE, sb.to_item(remaining[idx]));
			remaining.delete(idx);
			if ($urandom_range(7) == 0)
				send_command(bll_pkg::CMD_SEARCH, pick_key());
		end
		send_command(bll_pkg::CMD_DELETE, pick_key());
		send_command(bll_pkg::CMD_READ_OUT, $urandom);
		send_command(bll_pkg::CMD_SEARCH, $urandom);
	endtask

	initial begin : main_sequence
		int episode;
		int i;
		sb = new;
		arst_n               = 1'b0;
		request_ch.valid     = 1'b0;
		request_ch.cmd       = bll_pkg::CMD_INS_FRONT;
		request_ch.key_value = '0;
		known_items          = 0;
		set_idling(0);
		key_pool[0] = 32'sh0000_0000;
		key_pool[1] = -32'sd1;
		key_pool[2] = 32'sh8000_0000;
		key_pool[3] = 32'sh7fff_ffff;
		key_pool[4] = 32'sd1;
		for (i = 5; i < 8; i++)
			key_pool[i] = $urandom;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list cases first, then extreme keys and each walk outcome.
		send_command(bll_pkg::CMD_READ_OUT, 32'sh7fff_ffff);
		send_command(bll_pkg::CMD_SEARCH, 32'sh7fff_ffff);
		send_command(bll_pkg::CMD_DELETE, 32'sh8000_0000);
		send_command(bll_pkg::CMD_INS_FRONT, 32'sh8000_0000);
		send_command(bll_pkg::CMD_INS_END, 32'sh7fff_ffff);
		send_command(bll_pkg::CMD_INS_FRONT, 32'sh0000_0000);
		send_command(bll_pkg::CMD_INS_END, -32'sd1);
		send_command(bll_pkg::CMD_READ_OUT, 32'sh5555_aaaa);
		send_command(bll_pkg::CMD_SEARCH, 32'sh7fff_ffff);
		send_command(bll_pkg::CMD_SEARCH, 32'sd12345);
		send_command(bll_pkg::CMD_INS_END, 32'sh8000_0000);
		send_command(bll_pkg::CMD_DELETE, 32'sh8000_0000);
		send_command(bll_pkg::CMD_DELETE, 32'sh0000_0000);
		send_command(bll_pkg::CMD_DELETE, 32'sh8000_0000);
		send_command(bll_pkg::CMD_DELETE, 32'sd777);
		send_command(3'd5, 32'sh1234_5678);
		send_command(3'd6, 32'sh8765_4321);
		send_command(3'd7, -32'sd1);
		send_command(bll_pkg::CMD_READ_OUT, 32'sh0000_0000);
		send_command(bll_pkg::CMD_INS_END, 32'sd5);
		send_command(bll_pkg::CMD_READ_OUT, -32'sd1);
		wait_drained();

		// Every idling phase runs at least once.
		episode = 0;
		while (episode < 4 || known_items < TOTAL_ITEMS) begin
			set_idling(episode);
			if (episode == 0 || $urandom_range(4) == 0)
				fill_burst();
			else if ($urandom_range(3) == 0)
				drain_burst();
			else
				mixed_burst();
			if ($urandom_range(3) == 0)
				wait_drained();
			episode++;
		end

		wait_drained();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bll_pkg.sv
hw/rtl/bll_if.sv
hw/rtl/bll_ram.sv
hw/rtl/bounded_linked_list_engine_unit.sv
dv/bounded_linked_list_engine_unit_tb.sv
